>>> rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// Used by every module of the block; no dependencies.
package rmq_pkg;

   // Number format and derived widths
   localparam int FRAC_BITS = 30;
   localparam int ELEM_W    = 32;                 // matrix and quaternion elements
   localparam int THR_W     = 31;                 // trace threshold register
   localparam int TRACE_W   = ELEM_W + 2;         // sum of three elements
   localparam int RAD_W     = ELEM_W + 3;         // one plus/minus three elements
   localparam int R_W       = FRAC_BITS + 4;      // clamped radicand, up to 8.0
   localparam int X_W       = 2 * (FRAC_BITS + 2);// radicand scaled for the root
   localparam int ROOT_W    = X_W / 2;            // root bits, one per step
   localparam int SQ_STEPS  = ROOT_W;
   localparam int SREM_W    = ROOT_W + 4;         // root partial remainder
   localparam int NUM_W     = ELEM_W + 1;         // sum or difference of two elements
   localparam int D_W       = ROOT_W + 1;         // divisor 2t
   localparam int DREM_W    = D_W + 1;            // divider partial remainder
   localparam int Q_W       = FRAC_BITS + 1;      // quotient bits before saturation
   localparam int DIV_STEPS = Q_W;
   localparam int LANES     = 3;

   localparam logic [ELEM_W-1:0] ONE_Q   = ELEM_W'(64'd1 << FRAC_BITS);
   localparam logic [RAD_W-1:0]  RAD_ONE = RAD_W'(64'd1 << FRAC_BITS);
   localparam logic [RAD_W-1:0]  RAD_MAX = RAD_W'(64'd8 << FRAC_BITS);

   // Branch codes
   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_M11   = 2'd1;
   localparam logic [1:0] BR_M22   = 2'd2;
   localparam logic [1:0] BR_M33   = 2'd3;

   // Width of the register byte address
   localparam int CSR_ADDR_W = 3;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [NUM_W-1:0]  num_type;

   typedef struct packed {
      elem_type m33, m32, m31, m23, m22, m21, m13, m12, m11;
   } mat_type;

   // Item context through the root pipeline: branch, invalid flag and the
   // three off-diagonal numerators in x, y, z, w order with the diagonal skipped
   typedef struct packed {
      logic [1:0] branch;
      logic       bad;
      num_type    n2, n1, n0;
   } ctx_type;

   typedef struct packed {
      logic [1:0] branch;
      logic       bad;
   } meta_type;

   typedef struct packed {
      logic              neg;
      logic              sat;
      logic [DREM_W-1:0] rem;
      logic [Q_W-1:0]    q;
   } lane_type;

   typedef struct packed {
      elem_type   x, y, z, w;
      logic [1:0] branch;
      logic       bad;
   } quat_type;

endpackage

>>> rtl/rmq_front.sv
// Front end: trace, branch choice, radicand and numerators (two stages).
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  mat_type          mat,
   input  logic [THR_W-1:0] threshold,
   output logic             out_valid,
   output logic [R_W-1:0]   out_r,
   output ctx_type          out_ctx
);

   // Stage A registers
   logic                            a_vld_ff;
   logic signed [TRACE_W-1:0]       trace_ff;
   logic signed [RAD_W-1:0]         rad_ff [4];
   logic                            c11_ff, c22_ff;
   num_type d_zy_ff, d_xz_ff, d_yx_ff, s_xy_ff, s_xz_ff, s_yz_ff;

   // Stage B registers
   logic            b_vld_ff;
   logic [R_W-1:0]  r_ff;
   ctx_type         ctx_ff;

   // Stage B next values
   logic [1:0]              br_in;
   logic signed [RAD_W-1:0] rad_sel;
   logic                    bad_in;
   logic [R_W-1:0]          r_in;
   ctx_type                 ctx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
      end
   end

   // Stage A: sums, all four radicands, diagonal comparisons
   always_ff @(posedge clock) begin
      if (adv) begin
         trace_ff  <= TRACE_W'(mat.m11) + TRACE_W'(mat.m22) + TRACE_W'(mat.m33);
         rad_ff[0] <= $signed(RAD_ONE) + RAD_W'(mat.m11) + RAD_W'(mat.m22)
                      + RAD_W'(mat.m33);
         rad_ff[1] <= $signed(RAD_ONE) + RAD_W'(mat.m11) - RAD_W'(mat.m22)
                      - RAD_W'(mat.m33);
         rad_ff[2] <= $signed(RAD_ONE) + RAD_W'(mat.m22) - RAD_W'(mat.m11)
                      - RAD_W'(mat.m33);
         rad_ff[3] <= $signed(RAD_ONE) + RAD_W'(mat.m33) - RAD_W'(mat.m11)
                      - RAD_W'(mat.m22);
         c11_ff    <= (mat.m11 > mat.m22) && (mat.m11 > mat.m33);
         c22_ff    <= mat.m22 > mat.m33;
         d_zy_ff   <= NUM_W'(mat.m32) - NUM_W'(mat.m23);
         d_xz_ff   <= NUM_W'(mat.m13) - NUM_W'(mat.m31);
         d_yx_ff   <= NUM_W'(mat.m21) - NUM_W'(mat.m12);
         s_xy_ff   <= NUM_W'(mat.m12) + NUM_W'(mat.m21);
         s_xz_ff   <= NUM_W'(mat.m13) + NUM_W'(mat.m31);
         s_yz_ff   <= NUM_W'(mat.m23) + NUM_W'(mat.m32);
      end
   end

   // Stage B: pick the branch, clamp the radicand, route numerators
   always_comb begin
      if (trace_ff > $signed({{(TRACE_W-THR_W){1'b0}}, threshold})) br_in = BR_TRACE;
      else if (c11_ff) br_in = BR_M11;
      else if (c22_ff) br_in = BR_M22;
      else             br_in = BR_M33;

      rad_sel = rad_ff[br_in];
      bad_in  = rad_sel[RAD_W-1] || (rad_sel == '0);
      if (rad_sel > $signed(RAD_MAX)) r_in = R_W'(RAD_MAX);
      else                            r_in = rad_sel[R_W-1:0];

      ctx_in.branch = br_in;
      ctx_in.bad    = bad_in;
      case (br_in)
         BR_TRACE: begin
            ctx_in.n0 = d_zy_ff; ctx_in.n1 = d_xz_ff; ctx_in.n2 = d_yx_ff;
         end
         BR_M11: begin
            ctx_in.n0 = s_xy_ff; ctx_in.n1 = s_xz_ff; ctx_in.n2 = d_zy_ff;
         end
         BR_M22: begin
            ctx_in.n0 = s_xy_ff; ctx_in.n1 = s_yz_ff; ctx_in.n2 = d_xz_ff;
         end
         default: begin
            ctx_in.n0 = s_xz_ff; ctx_in.n1 = s_yz_ff; ctx_in.n2 = d_yx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff   <= r_in;
         ctx_ff <= ctx_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_r     = r_ff;
   assign out_ctx   = ctx_ff;

endmodule

>>> rtl/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, context carried along.
// Depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [R_W-1:0]    in_r,
   input  ctx_type           in_ctx,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output ctx_type           out_ctx
);

   logic              vld_ff  [SQ_STEPS];
   logic [ROOT_W-1:0] root_ff [SQ_STEPS];
   logic [SREM_W-1:0] rem_ff  [SQ_STEPS];
   logic [X_W-1:0]    x_ff    [SQ_STEPS];
   ctx_type           ctx_ff  [SQ_STEPS];

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
      logic              vld_src;
      logic [ROOT_W-1:0] root_src;
      logic [SREM_W-1:0] rem_src;
      logic [X_W-1:0]    x_src;
      ctx_type           ctx_src;
      logic [SREM_W-1:0] rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_in;
      logic              ge;

      if (j == 0) begin : g_first
         assign vld_src  = in_valid;
         assign root_src = '0;
         assign rem_src  = '0;
         assign x_src    = {in_r, {(X_W-R_W){1'b0}}};
         assign ctx_src  = in_ctx;
      end else begin : g_next
         assign vld_src  = vld_ff[j-1];
         assign root_src = root_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign x_src    = x_ff[j-1];
         assign ctx_src  = ctx_ff[j-1];
      end

      // Bring down two radicand bits and try root*4+1
      assign rem_sh  = {rem_src[SREM_W-3:0], x_src[X_W-1 -: 2]};
      assign trial   = {{(SREM_W-ROOT_W-2){1'b0}}, root_src, 2'b01};
      assign ge      = rem_sh >= trial;
      assign rem_in  = ge ? rem_sh - trial : rem_sh;
      assign root_in = {root_src[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset)    vld_ff[j] <= 1'b0;
         else if (adv) vld_ff[j] <= vld_src;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[j] <= root_in;
            rem_ff[j]  <= rem_in;
            x_ff[j]    <= {x_src[X_W-3:0], 2'b00};
            ctx_ff[j]  <= ctx_src;
         end
      end
   end

   assign out_valid = vld_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1];
   assign out_ctx   = ctx_ff[SQ_STEPS-1];

endmodule

>>> rtl/rmq_div.sv
// Three pipelined restoring dividers (n / 2t), then saturation and assembly.
// Depends on rmq_pkg.
module rmq_div import rmq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_root,
   input  ctx_type           in_ctx,
   output logic              out_valid,
   output quat_type          out_quat
);

   // Preparation stage: magnitudes, signs, early overflow
   logic                   p_vld_ff;
   logic [ROOT_W-1:0]      p_t_ff;
   meta_type               p_meta_ff;
   lane_type [LANES-1:0]   p_lane_ff;
   lane_type [LANES-1:0]   p_lane_in;
   num_type  [LANES-1:0]   nums;

   // Division steps
   logic                 vld_ff  [DIV_STEPS];
   logic [ROOT_W-1:0]    t_ff    [DIV_STEPS];
   meta_type             meta_ff [DIV_STEPS];
   lane_type [LANES-1:0] lane_ff [DIV_STEPS];

   // Output stage
   logic     o_vld_ff;
   quat_type quat_ff;
   quat_type quat_in;

   assign nums = {in_ctx.n2, in_ctx.n1, in_ctx.n0};

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic [NUM_W-1:0] mag;
         mag = nums[i][NUM_W-1] ? NUM_W'(-nums[i]) : NUM_W'(nums[i]);
         p_lane_in[i].neg = nums[i][NUM_W-1];
         p_lane_in[i].sat = {1'b0, mag} >= {in_root, 2'b00};
         p_lane_in[i].rem = {1'b0, mag};
         p_lane_in[i].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    p_vld_ff <= 1'b0;
      else if (adv) p_vld_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_t_ff           <= in_root;
         p_meta_ff.branch <= in_ctx.branch;
         p_meta_ff.bad    <= in_ctx.bad;
         p_lane_ff        <= p_lane_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic                 vld_src;
      logic [ROOT_W-1:0]    t_src;
      meta_type             meta_src;
      lane_type [LANES-1:0] lane_src;
      lane_type [LANES-1:0] lane_in;

      if (k == 0) begin : g_first
         assign vld_src  = p_vld_ff;
         assign t_src    = p_t_ff;
         assign meta_src = p_meta_ff;
         assign lane_src = p_lane_ff;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign t_src    = t_ff[k-1];
         assign meta_src = meta_ff[k-1];
         assign lane_src = lane_ff[k-1];
      end

      // One quotient bit per lane: compare, subtract, shift
      always_comb begin
         for (int i = 0; i < LANES; i++) begin
            logic [DREM_W-1:0] dv, r2;
            logic              ge;
            dv = {1'b0, t_src, 1'b0};
            ge = lane_src[i].rem >= dv;
            r2 = ge ? lane_src[i].rem - dv : lane_src[i].rem;
            lane_in[i].neg = lane_src[i].neg;
            lane_in[i].sat = lane_src[i].sat;
            lane_in[i].rem = {r2[DREM_W-2:0], 1'b0};
            lane_in[i].q   = {lane_src[i].q[Q_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset)    vld_ff[k] <= 1'b0;
         else if (adv) vld_ff[k] <= vld_src;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            t_ff[k]    <= t_src;
            meta_ff[k] <= meta_src;
            lane_ff[k] <= lane_in;
         end
      end
   end

   // Saturate, apply signs, place the diagonal term by branch, zero invalid items
   always_comb begin
      elem_type              qv [LANES];
      elem_type              h;
      logic [ROOT_W-2:0]     half;
      lane_type [LANES-1:0]  ln;
      meta_type              mt;
      ln   = lane_ff[DIV_STEPS-1];
      mt   = meta_ff[DIV_STEPS-1];
      half = t_ff[DIV_STEPS-1][ROOT_W-1:1];
      for (int i = 0; i < LANES; i++) begin
         logic [ELEM_W-1:0] mg;
         if (ln[i].sat || ({1'b0, ln[i].q} > ONE_Q)) mg = ONE_Q;
         else                                        mg = {1'b0, ln[i].q};
         qv[i] = ln[i].neg ? -$signed(mg) : $signed(mg);
      end
      h = ({1'b0, half} > ONE_Q) ? $signed(ONE_Q) : $signed({1'b0, half});

      case (mt.branch)
         BR_TRACE: begin
            quat_in.x = qv[0]; quat_in.y = qv[1]; quat_in.z = qv[2]; quat_in.w = h;
         end
         BR_M11: begin
            quat_in.x = h; quat_in.y = qv[0]; quat_in.z = qv[1]; quat_in.w = qv[2];
         end
         BR_M22: begin
            quat_in.x = qv[0]; quat_in.y = h; quat_in.z = qv[1]; quat_in.w = qv[2];
         end
         default: begin
            quat_in.x = qv[0]; quat_in.y = qv[1]; quat_in.z = h; quat_in.w = qv[2];
         end
      endcase
      if (mt.bad) begin
         quat_in.x = '0; quat_in.y = '0; quat_in.z = '0; quat_in.w = '0;
      end
      quat_in.branch = mt.branch;
      quat_in.bad    = mt.bad;
   end

   always_ff @(posedge clock) begin
      if (reset)    o_vld_ff <= 1'b0;
      else if (adv) o_vld_ff <= vld_ff[DIV_STEPS-1];
   end

   always_ff @(posedge clock) begin
      if (adv) quat_ff <= quat_in;
   end

   assign out_valid = o_vld_ff;
   assign out_quat  = quat_ff;

endmodule

>>> rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix (Q2.30) to unit quaternion, Shepperd's method.
// Input item on req_*: nine matrix elements packed in req_tdata.
// Result item on rsp_*: quaternion in rsp_tdata, branch and invalid flag in rsp_tuser.
// One register, trace_threshold, on the csr_* port at byte address 0; the user must
// write it only while the block is idle; the block itself does not enforce this.
// Throughput: one item per cycle unless the output stalls. An item reaches
// rsp_tvalid through 68 register stages (the first loads at the accepting edge):
// 2 front-end stages, 32 square-root stages (one root bit each), 1 divider setup
// stage, 31 divider stages (one quotient bit each), 1 assembly stage and the
// output register.
// Reset clears all valid bits and sets trace_threshold to zero.
// A stalled result holds in the output register; the pipeline behind it keeps
// moving and accepting items as long as its last stage is empty, and halts as a
// whole otherwise, so nothing is lost or repeated.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: m11, m12, m13, m21, m22, m23, m31, m32, m33 (32 bits each, low first)
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [9*ELEM_W-1:0]   req_tdata,
   // rsp_tdata: quat_x, quat_y, quat_z, quat_w (32 bits each, low first)
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [4*ELEM_W-1:0]   rsp_tdata,
   // rsp_tuser: branch_used [1:0], invalid [2]
   output logic [2:0]            rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [THR_W-1:0] thr_ff;
   logic             adv;
   mat_type          mat;

   logic              f_vld, s_vld, d_vld;
   logic [R_W-1:0]    f_r;
   ctx_type           f_ctx, s_ctx;
   logic [ROOT_W-1:0] s_root;
   quat_type          d_quat;

   logic     out_vld_ff, out_vld_in;
   quat_type out_ff;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-THR_W){1'b0}}, thr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   // Pipeline advances unless a finished item is blocked at the output
   assign adv        = !d_vld || !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   assign mat.m11 = req_tdata[0*ELEM_W +: ELEM_W];
   assign mat.m12 = req_tdata[1*ELEM_W +: ELEM_W];
   assign mat.m13 = req_tdata[2*ELEM_W +: ELEM_W];
   assign mat.m21 = req_tdata[3*ELEM_W +: ELEM_W];
   assign mat.m22 = req_tdata[4*ELEM_W +: ELEM_W];
   assign mat.m23 = req_tdata[5*ELEM_W +: ELEM_W];
   assign mat.m31 = req_tdata[6*ELEM_W +: ELEM_W];
   assign mat.m32 = req_tdata[7*ELEM_W +: ELEM_W];
   assign mat.m33 = req_tdata[8*ELEM_W +: ELEM_W];

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .mat       (mat),
      .threshold (thr_ff),
      .out_valid (f_vld),
      .out_r     (f_r),
      .out_ctx   (f_ctx)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_vld),
      .in_r      (f_r),
      .in_ctx    (f_ctx),
      .out_valid (s_vld),
      .out_root  (s_root),
      .out_ctx   (s_ctx)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_vld),
      .in_root   (s_root),
      .in_ctx    (s_ctx),
      .out_valid (d_vld),
      .out_quat  (d_quat)
   );

   // Output register
   always_comb begin
      if (adv && d_vld) out_vld_in = 1'b1;
      else if (rsp_tready) out_vld_in = 1'b0;
      else out_vld_in = out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= out_vld_in;
   end

   always_ff @(posedge clock) begin
      if (adv && d_vld) out_ff <= d_quat;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.w, out_ff.z, out_ff.y, out_ff.x};
   assign rsp_tuser  = {out_ff.bad, out_ff.branch};

endmodule
